// ===== src/tuph_pkg.sv =====
`timescale 1ns / 1ps

package tuph_pkg;

  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [14:0] TcpSumWord = 15'd8;
  localparam logic [14:0] UdpSumWord = 15'd3;

  // two-entry queues on both sides of the accumulator
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    CmdAddr = 1'b0,
    CmdSeg  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        command;
    logic [15:0] data_word;
    logic        odd_byte;
    logic        last;
    logic [7:0]  protocol;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        status;
  } out_item_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic        proto_ok;
    logic [15:0] tail_sum;   // protocol + byte count, folded
  } mid_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

// ===== src/tcp_udp_pseudo_header_checksum_top.sv =====
`timescale 1ns / 1ps
// Each word is registered in the mid queue, each result in the result queue. Throughput: one
// word per cycle while results drain; the front classifies, the back runs one end-around-carry
// add per word, and two-entry queues sit between front and back and at the result side.
// Reset (rst_ni, async, active low) clears the running sum, the byte count and both queues.
module tcp_udp_pseudo_header_checksum_top import tuph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  mid_item_t mid_in, mid_out;
  q_stat_t   mid_stat, out_stat;
  logic      accept;
  logic      mid_pop;

  assign accept = push && !mid_stat.full;
  assign full   = mid_stat.full;
  assign empty  = out_stat.empty;

  tuph_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .mid_o    (mid_in)
  );

  tuph_mid_queue u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (mid_in),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .stat_o (mid_stat)
  );

  tuph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_i      (mid_out),
    .mid_stat_i (mid_stat),
    .mid_pop_o  (mid_pop),
    .pop_i      (pop),
    .result_o   (result_o),
    .out_stat_o (out_stat)
  );

  a_mid_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_stat.full && mid_stat.empty))
    else $error("mid queue full and empty at once");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !mid_stat.empty)
    else $error("accepted transaction missing from mid queue");

  a_bad_proto_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status) |-> (result_o.checksum == 16'd0))
    else $error("error status with nonzero checksum");

endmodule

// ===== src/tuph_front.sv =====
`timescale 1ns / 1ps

module tuph_front import tuph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output mid_item_t mid_o
);

  logic [15:0] count_q, count_d;
  logic [15:0] count_next;
  logic [14:0] index;
  logic        is_seg;
  logic        is_tcp, is_udp;
  logic        zero_field;
  logic [15:0] word;

  assign is_seg = (cmd_e'(item_i.command) == CmdSeg);
  assign is_tcp = (item_i.protocol == ProtoTcp);
  assign is_udp = (item_i.protocol == ProtoUdp);
  assign index  = count_q[15:1];

  // the segment's own checksum field is summed as zero
  assign zero_field = (is_tcp && index == TcpSumWord) || (is_udp && index == UdpSumWord);

  always_comb begin
    word       = item_i.data_word;
    count_next = count_q;
    if (is_seg) begin
      if (zero_field) begin
        word = 16'd0;
      end
      if (item_i.odd_byte) begin
        word       = {word[15:8], 8'h00};
        count_next = count_q + 16'd1;
      end else begin
        count_next = count_q + 16'd2;
      end
    end
  end

  assign count_d = item_i.last ? 16'd0 : count_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 16'd0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign mid_o.word     = word;
  assign mid_o.last     = item_i.last;
  assign mid_o.proto_ok = is_tcp || is_udp;
  assign mid_o.tail_sum = oc_add({8'h00, item_i.protocol}, count_next);

endmodule

// ===== src/tuph_mid_queue.sv =====
`timescale 1ns / 1ps

module tuph_mid_queue import tuph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mid_item_t data_i,
  input  logic      pop_i,
  output mid_item_t data_o,
  output q_stat_t   stat_o
);

  mid_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ===== src/tuph_back.sv =====
`timescale 1ns / 1ps

module tuph_back import tuph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mid_item_t mid_i,
  input  q_stat_t   mid_stat_i,
  output logic      mid_pop_o,
  input  logic      pop_i,
  output out_item_t result_o,
  output q_stat_t   out_stat_o
);

  logic [15:0]      sum_q, sum_d;
  logic [15:0]      sum_word;
  out_item_t        res;
  logic             res_push;
  out_item_t        oq_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign out_stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign out_stat_o.empty = (cnt_q == '0);

  // a last word waits until there is room for its result
  assign mid_pop_o = !mid_stat_i.empty && (!mid_i.last || !out_stat_o.full);
  assign res_push  = mid_pop_o && mid_i.last;
  assign do_pop    = pop_i && !out_stat_o.empty;

  assign sum_word = oc_add(sum_q, mid_i.word);
  assign sum_d    = mid_i.last ? 16'd0 : sum_word;

  always_comb begin
    if (mid_i.proto_ok) begin
      res.checksum = ~oc_add(sum_word, mid_i.tail_sum);
      res.status   = 1'b0;
    end else begin
      res.checksum = 16'd0;
      res.status   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= 16'd0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (mid_pop_o) begin
        sum_q <= sum_d;
      end
      if (res_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (res_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !res_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assign result_o = oq_q[rd_ptr_q];

endmodule

// ===== test/tcp_udp_pseudo_header_checksum_top_tb.sv =====
`timescale 1ns / 1ps

module tcp_udp_pseudo_header_checksum_top_tb;
  import tuph_pkg::*;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusBadProto = 1'b1;
  localparam int   MaxIdle        = 11;
  localparam int   SettleCycles   = 8;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item_i;
  logic      empty;
  logic      pop;
  out_item_t result_o;

  tcp_udp_pseudo_header_checksum_top DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  // predictor state
  logic [15:0] acc_sum;
  logic [15:0] seg_bytes;
  out_item_t   expected_sums[$];

  int mismatch_count = 0;
  int words_sent     = 0;
  bit tx_idle_en     = 1'b1;
  bit rx_idle_en     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("%0t ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    t = {1'b0, t[15:0]} + {16'd0, t[16]};
    return t[15:0];
  endfunction

  // advance the checksum state by one word; returns 1 when the word ends a packet
  function automatic bit checksum_step(input in_item_t it, output out_item_t res);
    logic [15:0] w;
    logic [15:0] idx;
    logic [15:0] s;
    w   = it.data_word;
    res = '0;
    if (it.command == CmdSeg) begin
      idx = seg_bytes >> 1;
      // the segment's own checksum field counts as zero
      if ((it.protocol == ProtoTcp && idx == 16'(TcpSumWord)) ||
          (it.protocol == ProtoUdp && idx == 16'(UdpSumWord)))
        w = '0;
      if (it.odd_byte) begin
        w[7:0]    = '0;
        seg_bytes = seg_bytes + 16'd1;
      end else begin
        seg_bytes = seg_bytes + 16'd2;
      end
    end
    acc_sum = fold_add(acc_sum, w);
    if (!it.last) return 1'b0;
    if (it.protocol == ProtoTcp || it.protocol == ProtoUdp) begin
      s = fold_add(acc_sum, {8'd0, it.protocol});
      s = fold_add(s, seg_bytes);
      res.checksum = ~s;
      res.status   = StatusOk;
    end else begin
      res.checksum = '0;
      res.status   = StatusBadProto;
    end
    acc_sum   = '0;
    seg_bytes = '0;
    return 1'b1;
  endfunction

  function automatic in_item_t make_word(input cmd_e cmd, input logic [15:0] data,
                                         input logic odd, input logic fin,
                                         input logic [7:0] proto);
    in_item_t w;
    w.command   = cmd;
    w.data_word = data;
    w.odd_byte  = odd;
    w.last      = fin;
    w.protocol  = proto;
    return w;
  endfunction

  function automatic logic [7:0] pick_proto();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ProtoTcp;
    if (r < 8) return ProtoUdp;
    return 8'($urandom);
  endfunction

  task automatic send_word(input in_item_t it);
    int gap;
    out_item_t res;
    gap = tx_idle_en ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    words_sent++;
    if (checksum_step(it, res)) expected_sums.push_back(res);
  endtask

  // sender holds off until every outstanding checksum has come back
  task automatic wait_results_drained();
    push <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_packet(input int n_addr, input int seg_len, input logic [7:0] proto,
                             input bit ones);
    int n_seg;
    logic [15:0] d;
    bit fin;
    n_seg = (seg_len + 1) / 2;
    for (int i = 0; i < n_addr; i++) begin
      d = ones ? 16'hffff : 16'($urandom);
      send_word(make_word(CmdAddr, d, 1'b0, n_seg == 0 && i == n_addr - 1, proto));
    end
    for (int i = 0; i < n_seg; i++) begin
      fin = (i == n_seg - 1);
      d   = ones ? 16'hffff : 16'($urandom);
      send_word(make_word(CmdSeg, d, fin && seg_len[0], fin, proto));
    end
  endtask

  task automatic test_extremes();
    // packet ending on an address word, no segment
    send_word(make_word(CmdAddr, 16'hffff, 1'b0, 1'b1, ProtoTcp));
    // odd flag on an address word has no effect
    send_word(make_word(CmdAddr, 16'h0000, 1'b1, 1'b1, ProtoUdp));
    // protocols other than TCP and UDP
    send_word(make_word(CmdSeg, 16'hffff, 1'b0, 1'b1, 8'h00));
    send_word(make_word(CmdSeg, 16'h1234, 1'b1, 1'b1, 8'hff));
  endtask

  task automatic test_sum_field_zeroing();
    send_packet(0, 18, ProtoTcp, 1'b1);   // ends on TCP word 8
    send_packet(0, 7, ProtoUdp, 1'b1);    // ends on UDP word 3, odd byte
  endtask

  task automatic test_odd_midstream();
    send_word(make_word(CmdSeg, 16'habcd, 1'b1, 1'b0, ProtoTcp));
    send_word(make_word(CmdSeg, 16'hffff, 1'b0, 1'b0, ProtoTcp));
    send_word(make_word(CmdSeg, 16'h00ff, 1'b0, 1'b1, ProtoTcp));
  endtask

  task automatic test_wellformed_packets(input int n_words);
    int stop_at;
    int len;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
      send_packet(($urandom_range(0, 3) == 0) ? 16 : 4, len, pick_proto(), 1'b0);
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  task automatic test_broken_and_noise(input int n_words);
    int stop_at;
    int len;
    logic [7:0] base;
    logic [7:0] proto;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1) == 0) begin
        send_word(make_word(cmd_e'($urandom_range(0, 1)), 16'($urandom), 1'($urandom),
                            $urandom_range(0, 7) == 0, 8'($urandom)));
      end else begin
        // mixed commands, stray odd bytes and per-word protocol changes
        len  = $urandom_range(1, 20);
        base = pick_proto();
        for (int i = 0; i < len; i++) begin
          proto = ($urandom_range(0, 2) == 0) ? pick_proto() : base;
          send_word(make_word(($urandom_range(0, 4) == 0) ? CmdAddr : CmdSeg, 16'($urandom),
                              $urandom_range(0, 3) == 0, i == len - 1, proto));
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin : result_checker
    int stall;
    out_item_t want;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, MaxIdle) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result checksum=%h status=%b",
                                  result_o.checksum, result_o.status));
      end else begin
        want = expected_sums.pop_front();
        if (result_o.checksum !== want.checksum)
          report_mismatch($sformatf("checksum %h, expected %h",
                                    result_o.checksum, want.checksum));
        if (result_o.status !== want.status)
          report_mismatch($sformatf("status %b, expected %b", result_o.status, want.status));
      end
    end
  end

  initial begin
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    item_i    <= '0;
    acc_sum   = '0;
    seg_bytes = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_sum_field_zeroing();
    test_odd_midstream();
    wait_results_drained();
    test_wellformed_packets(900);
    test_broken_and_noise(300);

    push <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
